### rtl/core/wktt_pkg.sv
// Shared types and constants for the windowed key threshold tracker.
// Depends on nothing; the tracker and the testbench import it.

package wktt_pkg;

    // Field widths fixed by the interface
    localparam int KEY_W   = 8;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 9;
    localparam int WLEN_W  = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = CFG_IDX_W'(1);

    // Reset values and limits
    localparam logic [CNT_W-1:0]  THRESHOLD_RST  = CNT_W'(1);
    localparam logic [WLEN_W-1:0] WINDOW_LEN_RST = WLEN_W'(60);
    localparam logic [CNT_W-1:0]  CNT_MAX        = {CNT_W{1'b1}};

    typedef struct packed {
        logic [KEY_W-1:0]  vote_key;
        logic [TIME_W-1:0] vote_time;
    } vote_t;

    typedef struct packed {
        logic [CNT_W-1:0] key_count;
        logic             in_top;
        logic [CNT_W-1:0] top_size;
        logic [CNT_W-1:0] expired_count;
        logic             dropped;
    } result_t;

    // One entry of the window FIFO
    typedef struct packed {
        logic [KEY_W-1:0]  win_key;
        logic [TIME_W-1:0] win_time;
    } win_entry_t;

    // One entry of the per-key count table
    typedef struct packed {
        logic             top;
        logic [CNT_W-1:0] count;
    } cnt_entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXP_CHK,
        ST_EXP_UPD,
        ST_INS
    } state_t;

endpackage

### rtl/core/wktt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds until the next read. Depends on nothing.

module wktt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/windowed_key_threshold_tracker.sv
// Windowed key threshold tracker: vote FIFO and count table in RAM (wktt_pkg, wktt_ram).
// Flow: a vote is taken in ST_IDLE; with an empty window it goes straight to ST_INS, else
// ST_EXP_CHK tests the window head and ST_EXP_UPD writes back each expired vote's count,
// and ST_INS registers the result once the previous result has left the output register.
// One vote at a time: the next is taken the cycle after the result is registered.
// Reset: a sweep of all KEY_COUNT entries clears the counts with vote_ready low; config taken throughout.

module windowed_key_threshold_tracker
    import wktt_pkg::*;
#(
    parameter int WINDOW_DEPTH = 256,
    parameter int KEY_COUNT    = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  vote_valid,
    output logic                  vote_ready,
    input  vote_t                 vote,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PW = $clog2(WINDOW_DEPTH);
    localparam int OW = $clog2(WINDOW_DEPTH + 1);
    localparam int KW = $clog2(KEY_COUNT);
    localparam int NUM_RAW_KEYS = 1 << KEY_W;

    // raw key to table index, worked out at elaboration
    function automatic logic [NUM_RAW_KEYS*KW-1:0] key_map_build();
        logic [NUM_RAW_KEYS*KW-1:0] tbl;
        tbl = '0;
        for (int i = 0; i < NUM_RAW_KEYS; i++)
        begin
            tbl[i*KW +: KW] = KW'(i % KEY_COUNT);
        end
        return tbl;
    endfunction

    localparam logic [NUM_RAW_KEYS*KW-1:0] KEY_MAP = key_map_build();

    state_t state_reg, state_next;

    logic [PW-1:0]     head_reg, head_next;
    logic [PW-1:0]     tail_reg, tail_next;
    logic [OW-1:0]     occ_reg, occ_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  thr_reg;
    logic [WLEN_W-1:0] wlen_reg;
    logic [KW-1:0]     clr_reg, clr_next;
    logic [KW-1:0]     key_reg, key_next;
    logic [KW-1:0]     dkey_reg, dkey_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [CNT_W-1:0]  exp_reg, exp_next;
    result_t           res_reg, res_next;
    logic              res_valid_reg, res_valid_next;

    // RAM ports
    logic                    fifo_we, fifo_re;
    logic [PW-1:0]           fifo_raddr;
    win_entry_t              fifo_wdata, fifo_rdata;
    logic                    cnt_we, cnt_re;
    logic [KW-1:0]           cnt_waddr, cnt_raddr;
    cnt_entry_t              cnt_wdata, cnt_rdata;

    wktt_ram #(
        .WIDTH ($bits(win_entry_t)),
        .DEPTH (WINDOW_DEPTH)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (tail_reg),
        .wdata (fifo_wdata),
        .re    (fifo_re),
        .raddr (fifo_raddr),
        .rdata (fifo_rdata)
    );

    wktt_ram #(
        .WIDTH ($bits(cnt_entry_t)),
        .DEPTH (KEY_COUNT)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // FIFO pointer helpers and head check
    logic [PW-1:0]     head_inc, tail_inc;
    logic [TIME_W-1:0] age;
    logic              head_old, expire_ok;
    logic [KW-1:0]     head_key, vote_key_idx;
    logic              slot_free, clr_done, full;

    assign head_inc = (head_reg == PW'(WINDOW_DEPTH - 1)) ? '0 : head_reg + PW'(1);
    assign tail_inc = (tail_reg == PW'(WINDOW_DEPTH - 1)) ? '0 : tail_reg + PW'(1);
    assign age       = time_reg - fifo_rdata.win_time;
    assign head_old  = (fifo_rdata.win_time <= time_reg) && (age >= TIME_W'(wlen_reg));
    assign expire_ok = (occ_reg != '0) && head_old;
    assign head_key     = KEY_MAP[fifo_rdata.win_key*KW +: KW];
    assign vote_key_idx = KEY_MAP[vote.vote_key*KW +: KW];
    assign slot_free = !res_valid_reg || result_ready;
    assign clr_done  = (clr_reg == KW'(KEY_COUNT - 1));
    assign full      = (occ_reg == OW'(WINDOW_DEPTH));

    // count down / count up on the entry read back
    cnt_entry_t down_ent, up_ent;
    logic       down_leave, up_join;

    always_comb
    begin
        down_ent = cnt_rdata;
        if (cnt_rdata.count != '0)
        begin
            down_ent.count = cnt_rdata.count - CNT_W'(1);
        end
        down_leave = cnt_rdata.top && (down_ent.count < thr_reg);
        if (down_leave)
        begin
            down_ent.top = 1'b0;
        end

        up_ent = cnt_rdata;
        if (cnt_rdata.count < CNT_MAX)
        begin
            up_ent.count = cnt_rdata.count + CNT_W'(1);
        end
        up_join = !cnt_rdata.top && (up_ent.count >= thr_reg);
        if (up_join)
        begin
            up_ent.top = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (vote_valid)
                begin
                    state_next = (occ_reg != '0) ? ST_EXP_CHK : ST_INS;
                end
            end
            ST_EXP_CHK:
            begin
                state_next = expire_ok ? ST_EXP_UPD : ST_INS;
            end
            ST_EXP_UPD:
            begin
                state_next = ST_EXP_CHK;
            end
            ST_INS:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        total_next     = total_reg;
        clr_next       = clr_reg;
        key_next       = key_reg;
        dkey_next      = dkey_reg;
        time_next      = time_reg;
        exp_next       = exp_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !result_ready;
        vote_ready     = 1'b0;

        fifo_we    = 1'b0;
        fifo_re    = 1'b0;
        fifo_raddr = head_reg;
        fifo_wdata.win_key  = KEY_W'(key_reg);
        fifo_wdata.win_time = time_reg;
        cnt_we    = 1'b0;
        cnt_waddr = dkey_reg;
        cnt_wdata = down_ent;
        cnt_re    = 1'b0;
        cnt_raddr = key_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = '0;
                clr_next  = clr_reg + KW'(1);
            end
            ST_IDLE:
            begin
                vote_ready = 1'b1;
                if (vote_valid)
                begin
                    key_next  = vote_key_idx;
                    time_next = vote.vote_time;
                    exp_next  = '0;
                    if (occ_reg != '0)
                    begin
                        fifo_re = 1'b1;
                    end
                    else
                    begin
                        cnt_re    = 1'b1;
                        cnt_raddr = vote_key_idx;
                    end
                end
            end
            ST_EXP_CHK:
            begin
                if (expire_ok)
                begin
                    cnt_re     = 1'b1;
                    cnt_raddr  = head_key;
                    dkey_next  = head_key;
                    head_next  = head_inc;
                    occ_next   = occ_reg - OW'(1);
                    exp_next   = exp_reg + CNT_W'(1);
                    fifo_re    = 1'b1;
                    fifo_raddr = head_inc;
                end
                else
                begin
                    cnt_re    = 1'b1;
                    cnt_raddr = key_reg;
                end
            end
            ST_EXP_UPD:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = dkey_reg;
                cnt_wdata = down_ent;
                if (down_leave && (total_reg != '0))
                begin
                    total_next = total_reg - CNT_W'(1);
                end
            end
            ST_INS:
            begin
                if (slot_free)
                begin
                    res_valid_next         = 1'b1;
                    res_next.expired_count = exp_reg;
                    res_next.dropped       = full;
                    if (full)
                    begin
                        res_next.key_count = cnt_rdata.count;
                        res_next.in_top    = cnt_rdata.top;
                        res_next.top_size  = total_reg;
                    end
                    else
                    begin
                        cnt_we    = 1'b1;
                        cnt_waddr = key_reg;
                        cnt_wdata = up_ent;
                        fifo_we   = 1'b1;
                        tail_next = tail_inc;
                        occ_next  = occ_reg + OW'(1);
                        if (up_join)
                        begin
                            total_next = total_reg + CNT_W'(1);
                        end
                        res_next.key_count = up_ent.count;
                        res_next.in_top    = up_ent.top;
                        res_next.top_size  = up_join ? total_reg + CNT_W'(1) : total_reg;
                    end
                end
            end
            default:
            begin
                vote_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            total_reg     <= '0;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            total_reg     <= total_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THRESHOLD_RST;
            wlen_reg <= WINDOW_LEN_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_THRESHOLD)
            begin
                thr_reg <= cfg_data[CNT_W-1:0];
            end
            else if (cfg_index == REG_WINDOW_LEN)
            begin
                wlen_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        dkey_reg <= dkey_next;
        time_reg <= time_next;
        exp_reg  <= exp_next;
        res_reg  <= res_next;
    end

    assign cfg_ready    = 1'b1;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for windowed_key_threshold_tracker: a vote driver, a result monitor
// and a cycle-free tally model of the vote window. Depends on wktt_pkg and the block's RTL.

module testbench;
    import wktt_pkg::*;

    localparam int FIFO_DEPTH    = 256;
    localparam int KEY_SPACE     = 256;
    localparam int MAX_REPORTS   = 10;
    localparam int STUCK_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 20;

    // Register indexes that the block must ignore
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = {CFG_IDX_W{1'b1}};

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  vote_valid   = 1'b0;
    logic                  vote_ready;
    vote_t                 vote         = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // Tally model: vote window ring, per-key counts and top-set marks
    logic [KEY_W-1:0]  win_key_mem  [0:FIFO_DEPTH-1];
    logic [TIME_W-1:0] win_time_mem [0:FIFO_DEPTH-1];
    logic [KEY_W-1:0]  win_head     = '0;
    logic [KEY_W-1:0]  win_tail     = '0;
    int                win_fill     = 0;
    logic [CNT_W-1:0]  key_tally    [0:KEY_SPACE-1];
    logic              top_mark     [0:KEY_SPACE-1];
    logic [CNT_W-1:0]  top_members  = '0;
    logic [CNT_W-1:0]  thresh_reg   = THRESHOLD_RST;
    logic [WLEN_W-1:0] span_reg     = WINDOW_LEN_RST;

    // Stimulus and checking bookkeeping
    vote_t             vote_backlog[$];
    result_t           pending_tallies[$];
    result_t           want_tally;
    int                votes_queued = 0;
    int                vote_issued  = 0;
    int                vote_accepts = 0;
    int                cfg_accepts  = 0;
    int                send_gap     = 0;
    int                stall_left   = 0;
    int                stuck_cycles = 0;
    int                errors       = 0;
    bit                idle_free    = 1'b0;
    logic [TIME_W-1:0] clock_now    = '0;

    windowed_key_threshold_tracker #(
        .WINDOW_DEPTH (FIFO_DEPTH),
        .KEY_COUNT    (KEY_SPACE)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .vote_valid   (vote_valid),
        .vote_ready   (vote_ready),
        .vote         (vote),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else if (r < 98)
            return $urandom_range(12, 4);
        else
            return $urandom_range(60, 20);
    endfunction

    // Time step that sticks at the top of the range instead of wrapping
    function automatic logic [TIME_W-1:0] advance(logic [TIME_W-1:0] t, int unsigned d);
        logic [TIME_W:0] sum;
        sum = {1'b0, t} + (TIME_W + 1)'(d);
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

    function automatic void tally_drop(logic [KEY_W-1:0] k);
        if (key_tally[k] != '0)
            key_tally[k] = key_tally[k] - 1'b1;
        if (top_mark[k] && key_tally[k] < thresh_reg)
        begin
            top_mark[k] = 1'b0;
            if (top_members != '0)
                top_members = top_members - 1'b1;
        end
    endfunction

    function automatic void tally_add(logic [KEY_W-1:0] k);
        if (key_tally[k] != CNT_MAX)
            key_tally[k] = key_tally[k] + 1'b1;
        if (!top_mark[k] && key_tally[k] >= thresh_reg)
        begin
            top_mark[k] = 1'b1;
            top_members = top_members + 1'b1;
        end
    endfunction

    // Expire stale votes from the head, then append the new one unless the window is full
    function automatic result_t tally_vote(vote_t v);
        result_t           res;
        logic [TIME_W-1:0] head_time;
        logic [CNT_W-1:0]  expired;
        bit                scanning;
        expired  = '0;
        scanning = 1'b1;
        while (scanning && win_fill != 0)
        begin
            head_time = win_time_mem[win_head];
            if (head_time <= v.vote_time
                && (v.vote_time - head_time) >= {{(TIME_W - WLEN_W){1'b0}}, span_reg})
            begin
                tally_drop(win_key_mem[win_head]);
                win_head = win_head + 1'b1;
                win_fill = win_fill - 1;
                expired  = expired + 1'b1;
            end
            else
                scanning = 1'b0;
        end
        res.dropped = (win_fill >= FIFO_DEPTH);
        if (!res.dropped)
        begin
            win_key_mem[win_tail]  = v.vote_key;
            win_time_mem[win_tail] = v.vote_time;
            win_tail = win_tail + 1'b1;
            win_fill = win_fill + 1;
            tally_add(v.vote_key);
        end
        res.key_count     = key_tally[v.vote_key];
        res.in_top        = top_mark[v.vote_key];
        res.top_size      = top_members;
        res.expired_count = expired;
        return res;
    endfunction

    // Transfers seen at the rising edge: register writes, votes, results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_THRESHOLD)
                    thresh_reg = cfg_data[CNT_W-1:0];
                else if (cfg_index == REG_WINDOW_LEN)
                    span_reg = cfg_data[WLEN_W-1:0];
                cfg_accepts <= cfg_accepts + 1;
            end
            if (result_valid && result_ready)
            begin
                if (pending_tallies.size() == 0)
                begin
                    if (errors < MAX_REPORTS)
                        $display("unexpected result transfer: count=%0d top=%0b size=%0d",
                                 result.key_count, result.in_top, result.top_size);
                    errors++;
                end
                else
                begin
                    want_tally = pending_tallies.pop_front();
                    if (result.key_count !== want_tally.key_count
                        || result.in_top !== want_tally.in_top
                        || result.top_size !== want_tally.top_size
                        || result.expired_count !== want_tally.expired_count
                        || result.dropped !== want_tally.dropped)
                    begin
                        if (errors < MAX_REPORTS)
                            $display({"mismatch: expected count=%0d top=%0b size=%0d ",
                                      "expired=%0d drop=%0b, got count=%0d top=%0b size=%0d ",
                                      "expired=%0d drop=%0b"},
                                     want_tally.key_count, want_tally.in_top,
                                     want_tally.top_size, want_tally.expired_count,
                                     want_tally.dropped, result.key_count, result.in_top,
                                     result.top_size, result.expired_count, result.dropped);
                        errors++;
                    end
                end
            end
            if (vote_valid && vote_ready)
            begin
                pending_tallies.push_back(tally_vote(vote));
                vote_accepts <= vote_accepts + 1;
            end
        end
    end

    // Vote driver: holds an offered vote until its transfer, then waits out a gap
    always @(negedge clk)
    begin
        if (rst_n && vote_accepts == vote_issued)
        begin
            if (send_gap > 0)
            begin
                vote_valid <= 1'b0;
                send_gap = send_gap - 1;
            end
            else if (vote_backlog.size() != 0)
            begin
                vote        <= vote_backlog.pop_front();
                vote_valid  <= 1'b1;
                vote_issued = vote_issued + 1;
                send_gap    = idle_free ? 0 : pick_gap();
            end
            else
                vote_valid <= 1'b0;
        end
    end

    // Result sink: ready for one cycle, then a random stall, which may be empty
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            result_ready <= 1'b1;
            stall_left = idle_free ? 0 : pick_gap();
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((vote_valid && vote_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", STUCK_LIMIT);
            $display("** windowed_key_threshold_tracker: FAILED **");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        int target;
        target = cfg_accepts + 1;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        while (cfg_accepts != target)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_vote(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] stamp);
        vote_t v;
        v.vote_key  = key;
        v.vote_time = stamp;
        vote_backlog.push_back(v);
        votes_queued++;
    endtask

    // Waits until every queued vote is taken and has its result, then lets the block settle
    task automatic wait_drained();
        while (vote_accepts != votes_queued || pending_tallies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly rising timestamps over a key pool (any key if pool >= KEY_SPACE), with a few late and far-jump votes
    task automatic queue_votes(input int n, input int pool, input int unsigned step,
                               input int unsigned lead);
        logic [KEY_W-1:0] key_base;
        logic [KEY_W-1:0] key;
        int               r;
        key_base  = KEY_W'($urandom);
        clock_now = advance(clock_now, lead);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99, 0);
            if (r < 3 && clock_now > 32'd20)
                clock_now = clock_now - $urandom_range(20, 1);
            else if (r < 8)
                clock_now = advance(clock_now, $urandom_range(8 * step, step));
            else
                clock_now = advance(clock_now, $urandom_range(step, 0));
            if (pool >= KEY_SPACE)
                key = KEY_W'($urandom);
            else
                key = key_base + KEY_W'($urandom_range(pool - 1, 0));
            push_vote(key, clock_now);
        end
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] span,
                             input int n, input int pool, input int unsigned step,
                             input int unsigned lead);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_WINDOW_LEN, span);
        idle_free = ($urandom_range(3, 0) == 0);
        queue_votes(n, pool, step, lead);
        wait_drained();
    endtask

    initial
    begin
        for (int k = 0; k < KEY_SPACE; k++)
        begin
            key_tally[k] = '0;
            top_mark[k]  = 1'b0;
        end
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: expiry at the window edge, a late vote blocking the head
        push_vote(8'd0, 32'd0);
        push_vote(8'd255, 32'd0);
        push_vote(8'd0, 32'd59);
        push_vote(8'd0, 32'd60);
        push_vote(8'd5, 32'd30);
        push_vote(8'd5, 32'd100);
        push_vote(8'hAA, 32'd125);
        push_vote(8'h55, 32'd200);
        wait_drained();

        // Zero threshold and zero window; spare indexes must be ignored
        write_reg(REG_THRESHOLD, 16'd0);
        write_reg(REG_WINDOW_LEN, 16'd0);
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'hFFFF);
        push_vote(8'd1, 32'd200);
        push_vote(8'd1, 32'd200);
        push_vote(8'd2, 32'd199);
        wait_drained();

        // Widest settings: set flags survive a threshold raise
        write_reg(REG_THRESHOLD, 16'hFFFF);
        write_reg(REG_WINDOW_LEN, 16'hFFFF);
        push_vote(8'd3, 32'd300);
        push_vote(8'd1, 32'd301);
        wait_drained();

        write_reg(REG_THRESHOLD, 16'h0100);
        write_reg(REG_WINDOW_LEN, 16'd1);
        push_vote(8'd2, 32'd302);
        push_vote(8'd2, 32'd302);
        wait_drained();
        clock_now = 32'd302;

        // Random phases over a spread of settings
        run_phase(16'd2, 16'd60, 120, 4, 8, 100);
        run_phase(16'd1, 16'd1, 100, 8, 2, 100);
        run_phase(16'd3, 16'hFFFF, 320, 6, 30, 100000);
        run_phase(16'h0100, 16'hFFFF, 300, 1, 0, 70000);
        run_phase(16'd0, 16'd0, 120, 16, 3, 100);
        run_phase(CFG_DATA_W'($urandom_range(8, 1)), CFG_DATA_W'($urandom_range(500, 1)),
                  150, 32, 20, 1000);
        run_phase(16'hFFFF, 16'd300, 100, KEY_SPACE, 10, 1000);
        run_phase(16'd4, 16'd1000, 150, 12, 12, 5000);
        run_phase({7'($urandom), 9'($urandom_range(6, 0))}, CFG_DATA_W'($urandom),
                  100, 8, 64, 32'h4000_0000);
        clock_now = 32'hFFFF_FF00;
        run_phase(16'd2, 16'd500, 100, 10, 40, 0);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_tallies.size() != 0)
        begin
            $display("%0d expected results never arrived", pending_tallies.size());
            errors++;
        end
        if (errors == 0)
            $display("** windowed_key_threshold_tracker: PASSED **");
        else
            $display("** windowed_key_threshold_tracker: FAILED **");
        $finish;
    end

endmodule

### files.f
rtl/core/wktt_pkg.sv
rtl/core/wktt_ram.sv
rtl/core/windowed_key_threshold_tracker.sv
tb/sv/testbench.sv
